### src/fpwb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_pkg
// Shared constants, request codes and the result record of the flash page
// write buffer.
// ----------------------------------------------------------------------------
package fpwb_pkg;

    localparam int PAGE_BYTES_DEF  = 128;
    localparam int FLASH_PAGES_DEF = 256;

    localparam int ADDR_W = 15;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_FLUSH = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              page_programmed;
    } t_rsp;

endpackage

### src/fpwb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_div
// Address split for the front end: page and offset of a 15-bit byte address,
// by reciprocal multiplication with the page size and the page count.
// ----------------------------------------------------------------------------
module fpwb_div
    import fpwb_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int FLASH_PAGES = FLASH_PAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_done,
    output logic [((FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1)-1:0] o_pg,
    output logic [$clog2(PAGE_BYTES)-1:0] o_off
);

    localparam int PG_W   = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1;
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int MUL_W  = ADDR_W + 2;
    localparam int PROD_W = ADDR_W + MUL_W;
    localparam int SH_A   = ADDR_W + $clog2(PAGE_BYTES);
    localparam int SH_B   = ADDR_W + $clog2(FLASH_PAGES);
    // ceil(2**sh / d): the quotient is exact for any dividend below 2**ADDR_W
    localparam longint REC_A = ((longint'(1) << SH_A) + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam longint REC_B = ((longint'(1) << SH_B) + FLASH_PAGES - 1) / FLASH_PAGES;

    logic              r_st1;
    logic              r_st2;
    logic              r_st3;
    logic              r_done;
    logic [ADDR_W-1:0] r_x;
    logic [ADDR_W-1:0] r_q1;
    logic [ADDR_W-1:0] r_q2;
    logic [OFF_W-1:0]  r_off;
    logic [PG_W-1:0]   r_pg;

    logic [PROD_W-1:0] c_prod_a;
    logic [PROD_W-1:0] c_prod_b;
    logic [ADDR_W-1:0] c_back_a;
    logic [ADDR_W-1:0] c_back_b;

    assign c_prod_a = PROD_W'(r_x) * PROD_W'(REC_A);
    assign c_prod_b = PROD_W'(r_q1) * PROD_W'(REC_B);
    assign c_back_a = r_q1 * ADDR_W'(PAGE_BYTES);
    assign c_back_b = r_q2 * ADDR_W'(FLASH_PAGES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1  <= 1'b0;
            r_st2  <= 1'b0;
            r_st3  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_st1  <= i_start;
            r_st2  <= r_st1;
            r_st3  <= r_st2;
            r_done <= r_st3;
        end
    end

    // one product per cycle: addr / PAGE_BYTES, then that quotient / FLASH_PAGES
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_addr;
        end
        if (r_st1) begin
            r_q1 <= ADDR_W'(c_prod_a >> SH_A);
        end
        if (r_st2) begin
            r_off <= OFF_W'(r_x - c_back_a);
            r_q2  <= ADDR_W'(c_prod_b >> SH_B);
        end
        if (r_st3) begin
            r_pg <= PG_W'(r_q1 - c_back_b);
        end
    end

    assign o_done = r_done;
    assign o_pg   = r_pg;
    assign o_off  = r_off;

endmodule

### src/fpwb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_fifo
// Two-entry register queue with full and empty flags.
// ----------------------------------------------------------------------------
module fpwb_fifo
    import fpwb_pkg::*;
#(
    parameter int W = DATA_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_rdata
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;

    logic c_wr;
    logic c_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign c_wr    = i_push && !o_full;
    assign c_rd    = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (c_wr) begin
                r_wptr <= !r_wptr;
            end
            if (c_rd) begin
                r_rptr <= !r_rptr;
            end
            unique case ({c_wr, c_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### src/fpwb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_front
// Request front end: takes a request, splits the address into page and
// offset with the constant divider and hands the decoded command onward.
// ----------------------------------------------------------------------------
module fpwb_front
    import fpwb_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int FLASH_PAGES = FLASH_PAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_req_type,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_kind             o_kind,
    output logic [((FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1)-1:0] o_pg,
    output logic [$clog2(PAGE_BYTES)-1:0] o_off,
    output logic [DATA_W-1:0] o_data
);

    localparam int PG_W  = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1;
    localparam int OFF_W = $clog2(PAGE_BYTES);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_SPLIT = 3'b010,
        F_PUSH  = 3'b100
    } t_fstate;

    t_fstate           r_state, n_state;
    t_kind             r_kind, n_kind;
    logic [PG_W-1:0]   r_pg, n_pg;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [DATA_W-1:0] r_data, n_data;

    logic              c_accept;
    logic              split_start;
    logic              split_done;
    logic [PG_W-1:0]   split_pg;
    logic [OFF_W-1:0]  split_off;

    fpwb_div #(
        .PAGE_BYTES  (PAGE_BYTES),
        .FLASH_PAGES (FLASH_PAGES)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (split_start),
        .i_addr  (i_addr),
        .o_done  (split_done),
        .o_pg    (split_pg),
        .o_off   (split_off)
    );

    assign o_full   = (r_state != F_IDLE) || i_hold;
    assign c_accept = i_push && !o_full;

    // page = (addr / PAGE_BYTES) mod FLASH_PAGES, offset = addr mod PAGE_BYTES
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_pg        = r_pg;
        n_off       = r_off;
        n_data      = r_data;
        split_start = 1'b0;
        o_valid     = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (c_accept) begin
                    n_kind = t_kind'(i_req_type);
                    n_data = i_data;
                    if (t_kind'(i_req_type) == K_WRITE || t_kind'(i_req_type) == K_READ) begin
                        split_start = 1'b1;
                        n_state     = F_SPLIT;
                    end else begin
                        n_pg    = '0;
                        n_off   = '0;
                        n_state = F_PUSH;
                    end
                end
            end
            F_SPLIT: begin
                if (split_done) begin
                    n_pg    = split_pg;
                    n_off   = split_off;
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_pg   <= n_pg;
        r_off  <= n_off;
        r_data <= n_data;
    end

    assign o_kind = r_kind;
    assign o_pg   = r_pg;
    assign o_off  = r_off;
    assign o_data = r_data;

endmodule

### src/fpwb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpwb_back
// Command engine: holds the flash array and the page buffer, programs the
// open page back, loads new pages and answers reads.
// ----------------------------------------------------------------------------
module fpwb_back
    import fpwb_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int FLASH_PAGES = FLASH_PAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_clearing,
    input  logic              i_valid,
    output logic              o_pop,
    input  t_kind             i_kind,
    input  logic [((FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1)-1:0] i_pg,
    input  logic [$clog2(PAGE_BYTES)-1:0] i_off,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_rsp_push,
    input  logic              i_rsp_full,
    output t_rsp              o_rsp
);

    localparam int PG_W   = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1;
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int CNT_W  = $clog2(PAGE_BYTES + 1);
    localparam int STORE  = PAGE_BYTES * FLASH_PAGES;
    localparam int FL_W   = $clog2(STORE);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_PROG  = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_RWAIT = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_bstate;

    logic [DATA_W-1:0] r_flash [STORE];
    logic [DATA_W-1:0] r_buf   [PAGE_BYTES];
    logic [DATA_W-1:0] r_fl_rd;
    logic [DATA_W-1:0] r_bf_rd;

    t_bstate           r_state, n_state;
    logic [FL_W-1:0]   r_clr, n_clr;
    logic              r_open, n_open;
    logic [PG_W-1:0]   r_open_pg, n_open_pg;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_cp_vld, n_cp_vld;
    logic [OFF_W-1:0]  r_cp_idx, n_cp_idx;
    t_kind             r_kind, n_kind;
    logic [PG_W-1:0]   r_pg, n_pg;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [DATA_W-1:0] r_data, n_data;
    logic [DATA_W-1:0] r_rd, n_rd;
    logic              r_prog, n_prog;

    logic [PG_W-1:0]   c_pg_sel;
    logic [FL_W-1:0]   c_base;
    logic              fl_we;
    logic [FL_W-1:0]   fl_waddr;
    logic [DATA_W-1:0] fl_wdata;
    logic [FL_W-1:0]   fl_raddr;
    logic              bf_we;
    logic [OFF_W-1:0]  bf_waddr;
    logic [DATA_W-1:0] bf_wdata;
    logic [OFF_W-1:0]  bf_raddr;

    assign c_pg_sel = (r_state == S_PROG) ? r_open_pg : r_pg;
    assign c_base   = FL_W'(c_pg_sel) * FL_W'(PAGE_BYTES);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_open    = r_open;
        n_open_pg = r_open_pg;
        n_cnt     = r_cnt;
        n_cp_vld  = 1'b0;
        n_cp_idx  = r_cnt[OFF_W-1:0];
        n_kind    = r_kind;
        n_pg      = r_pg;
        n_off     = r_off;
        n_data    = r_data;
        n_rd      = r_rd;
        n_prog    = r_prog;
        o_pop     = 1'b0;
        o_rsp_push = 1'b0;
        fl_we     = 1'b0;
        fl_waddr  = c_base + FL_W'(r_cp_idx);
        fl_wdata  = r_bf_rd;
        fl_raddr  = c_base + FL_W'(r_cnt[OFF_W-1:0]);
        bf_we     = 1'b0;
        bf_waddr  = r_cp_idx;
        // the byte being written replaces its flash copy while loading
        bf_wdata  = (r_cp_idx == r_off) ? r_data : r_fl_rd;
        bf_raddr  = r_cnt[OFF_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                fl_we    = 1'b1;
                fl_waddr = r_clr;
                fl_wdata = '1;
                if (r_clr == FL_W'(STORE - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop  = 1'b1;
                    n_kind = i_kind;
                    n_pg   = i_pg;
                    n_off  = i_off;
                    n_data = i_data;
                    n_rd   = '0;
                    n_prog = 1'b0;
                    n_cnt  = '0;
                    unique case (i_kind)
                        K_WRITE: begin
                            if (r_open && i_pg == r_open_pg) begin
                                bf_we    = 1'b1;
                                bf_waddr = i_off;
                                bf_wdata = i_data;
                                n_state  = S_DONE;
                            end else if (r_open) begin
                                n_state = S_PROG;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        K_READ:  n_state = r_open ? S_PROG : S_READ;
                        K_FLUSH: n_state = r_open ? S_PROG : S_DONE;
                        K_NONE:  n_state = S_DONE;
                    endcase
                end
            end
            S_PROG: begin
                // the buffer byte is read in the cycle before its flash write
                fl_we = r_cp_vld;
                if (r_cnt != CNT_W'(PAGE_BYTES)) begin
                    n_cp_vld = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end else begin
                    n_open = 1'b0;
                    n_prog = 1'b1;
                    n_cnt  = '0;
                    unique case (r_kind)
                        K_WRITE: n_state = S_LOAD;
                        K_READ:  n_state = S_READ;
                        K_FLUSH: n_state = S_DONE;
                        K_NONE:  n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                bf_we = r_cp_vld;
                if (r_cnt != CNT_W'(PAGE_BYTES)) begin
                    n_cp_vld = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end else begin
                    n_open    = 1'b1;
                    n_open_pg = r_pg;
                    n_state   = S_DONE;
                end
            end
            S_READ: begin
                fl_raddr = c_base + FL_W'(r_off);
                n_state  = S_RWAIT;
            end
            S_RWAIT: begin
                n_rd    = r_fl_rd;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_rsp_push = !i_rsp_full;
                if (!i_rsp_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_open    <= 1'b0;
            r_open_pg <= '0;
            r_cnt     <= '0;
            r_cp_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_open    <= n_open;
            r_open_pg <= n_open_pg;
            r_cnt     <= n_cnt;
            r_cp_vld  <= n_cp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_idx <= n_cp_idx;
        r_kind   <= n_kind;
        r_pg     <= n_pg;
        r_off    <= n_off;
        r_data   <= n_data;
        r_rd     <= n_rd;
        r_prog   <= n_prog;
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            r_flash[fl_waddr] <= fl_wdata;
        end
        r_fl_rd <= r_flash[fl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bf_we) begin
            r_buf[bf_waddr] <= bf_wdata;
        end
        r_bf_rd <= r_buf[bf_raddr];
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_rsp      = '{read_data: r_rd, page_programmed: r_prog};

endmodule

### src/flash_page_write_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_page_write_buffer
// Write-combining page buffer in front of a byte-addressed flash array.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: a transfer happens when push is
// high and full is low. Each request gives exactly one result, read from the
// result queue while empty is low and taken with pop.
// After reset the flash array is erased to 0xFF by a clearing pass over all
// PAGE_BYTES*FLASH_PAGES bytes (32768 by default); full stays high meanwhile.
// The front end splits the address by reciprocal multiplication, one product
// a cycle; a flush or unknown request skips it, with page and offset zero.
// A small queue lets the front split the next address while the back works.
// Back end: a write to the open page goes straight into the page buffer; a
// page miss programs the open page back, if any, and loads the new one, byte
// by byte through the single-byte ports of the flash array and page buffer.
// A read first programs an open page back, then reads its byte from flash.
// A stalled result side fills the two-entry result queue, then the back end
// and the request queue stall in turn; nothing is dropped.
// ----------------------------------------------------------------------------
module flash_page_write_buffer
    import fpwb_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int FLASH_PAGES = FLASH_PAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_req_type,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_data,
    output logic              empty,
    input  logic              pop,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_page_programmed
);

    localparam int PG_W  = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1;
    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int REQ_W = 2 + PG_W + OFF_W + DATA_W;
    localparam int RSP_W = $bits(t_rsp);

    logic              clearing;
    logic              f_valid;
    t_kind             f_kind;
    logic [PG_W-1:0]   f_pg;
    logic [OFF_W-1:0]  f_off;
    logic [DATA_W-1:0] f_data;

    logic              mq_full;
    logic              mq_empty;
    logic              mq_pop;
    logic [REQ_W-1:0]  mq_rdata;
    logic [1:0]        m_kind;
    logic [PG_W-1:0]   m_pg;
    logic [OFF_W-1:0]  m_off;
    logic [DATA_W-1:0] m_data;

    logic              rsp_push;
    logic              rq_full;
    t_rsp              rsp_in;
    t_rsp              rsp_out;
    logic [RSP_W-1:0]  rq_rdata;

    fpwb_front #(
        .PAGE_BYTES  (PAGE_BYTES),
        .FLASH_PAGES (FLASH_PAGES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (clearing),
        .i_push     (push),
        .o_full     (full),
        .i_req_type (i_req_type),
        .i_addr     (i_addr),
        .i_data     (i_data),
        .o_valid    (f_valid),
        .i_ready    (!mq_full),
        .o_kind     (f_kind),
        .o_pg       (f_pg),
        .o_off      (f_off),
        .o_data     (f_data)
    );

    fpwb_fifo #(
        .W (REQ_W)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_wdata ({f_kind, f_pg, f_off, f_data}),
        .o_full  (mq_full),
        .i_pop   (mq_pop),
        .o_empty (mq_empty),
        .o_rdata (mq_rdata)
    );

    assign {m_kind, m_pg, m_off, m_data} = mq_rdata;

    fpwb_back #(
        .PAGE_BYTES  (PAGE_BYTES),
        .FLASH_PAGES (FLASH_PAGES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_valid    (!mq_empty),
        .o_pop      (mq_pop),
        .i_kind     (t_kind'(m_kind)),
        .i_pg       (m_pg),
        .i_off      (m_off),
        .i_data     (m_data),
        .o_rsp_push (rsp_push),
        .i_rsp_full (rq_full),
        .o_rsp      (rsp_in)
    );

    fpwb_fifo #(
        .W (RSP_W)
    ) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_push),
        .i_wdata (rsp_in),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (rq_rdata)
    );

    assign rsp_out           = t_rsp'(rq_rdata);
    assign o_read_data       = rsp_out.read_data;
    assign o_page_programmed = rsp_out.page_programmed;

endmodule
